[hdl/sprite_frame_sequencer_unit_macros.svh]
// Assertion macros for the sprite frame sequencer.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SPRITE_FRAME_SEQUENCER_UNIT_MACROS_SVH
`define SPRITE_FRAME_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sfs_pkg.sv]
// Shared types and constants of the sprite frame sequencer.
// Used by the datapath, controller and top level.
package sfs_pkg;

  localparam int PERIOD_W       = 20;
  localparam int COLS_W         = 7;
  localparam int COUNT_W        = 13;
  localparam int FRAME_W        = 12;
  localparam int FIELD_W        = 6;
  localparam int DEN_W          = 21;
  localparam int CFG_IDX_W      = 2;
  localparam int IN_DATA_W      = 24;
  localparam int OUT_DATA_W     = 32;
  localparam int MAX_COLUMNS    = 64;
  localparam int MAX_FRAMES     = 4096;
  localparam int TIME_WIDTH_DEF = 32;
  localparam int PERIOD_RESET   = 33333;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACROSS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd3;

  // Input kinds
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_PLAY = 1'b1;

  typedef enum logic [1:0] {
    DSEL_SKIP,
    DSEL_MOD,
    DSEL_CR
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     do_play;
    logic     do_accum;
    logic     div_start;
    div_sel_t div_sel;
    logic     skip_add;
    logic     take_num;
    logic     take_rem;
    logic     stop;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic action;
    logic running;
    logic looping;
    logic acc_ge;
    logic num_ge;
    logic div_done;
  } dp_status_t;

endpackage

[hdl/sfs_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Uses no package items.
module sfs_div #(
  parameter int NUM_W  = 34,
  parameter int DEN_W  = 21,
  parameter int STEP_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [STEP_W-1:0] steps,
  output logic [NUM_W-1:0]  quo,
  output logic [DEN_W-1:0]  rem,
  output logic              done
);

  logic [STEP_W-1:0] cnt_r;
  logic              done_r;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W:0]    r_sh, r_sub;
  logic              ge;

  always_comb begin
    r_sh    = {rem_r, quo_r[NUM_W-1]};
    r_sub   = r_sh - {1'b0, den_r};
    ge      = (r_sh >= {1'b0, den_r});
    rem_nxt = ge ? r_sub[DEN_W-1:0] : r_sh[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= steps;
      rem_r  <= '0;
      quo_r  <= num;
      den_r  <= den;
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      done_r <= (cnt_r == STEP_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

[hdl/sfs_dp.sv]
// Datapath: configuration registers, animation state, input latch, result register.
// Depends on sfs_pkg and sfs_div.
module sfs_dp #(
  parameter int TIME_WIDTH = sfs_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [sfs_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                in_tuser,
  input  logic                                cfg_wr_en,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfs_pkg::PERIOD_W-1:0]        cfg_wdata,
  input  sfs_pkg::ctrl_cmd_t                  cmd,
  output sfs_pkg::dp_status_t                 status,
  output logic [sfs_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int MAX_W  = (TIME_WIDTH > sfs_pkg::PERIOD_W) ? TIME_WIDTH : sfs_pkg::PERIOD_W;
  localparam int SUM_W  = MAX_W + 1;
  localparam int NUM_W  = MAX_W + 2;
  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam int PAD_W  = sfs_pkg::OUT_DATA_W - 2 * sfs_pkg::FIELD_W - sfs_pkg::FRAME_W - 3;

  // Configuration
  logic [sfs_pkg::PERIOD_W-1:0] period_r;
  logic [sfs_pkg::COLS_W-1:0]   cols_r;
  logic [sfs_pkg::COUNT_W-1:0]  count_r;

  // Animation state
  logic [TIME_WIDTH-1:0]       acc_r;
  logic [sfs_pkg::FRAME_W-1:0] frame_r;
  logic                        running_r;
  logic                        looping_r;

  // Item in flight
  logic                         action_r;
  logic [sfs_pkg::PERIOD_W-1:0] delta_r;
  logic                         repeat_r;
  logic                         adv_r;
  logic                         fin_r;
  logic [NUM_W-1:0]             num_r;
  logic [sfs_pkg::OUT_DATA_W-1:0] out_data_r;

  logic [sfs_pkg::COLS_W-1:0]   cfg_cols;
  logic [sfs_pkg::COUNT_W-1:0]  cfg_count;
  logic [SUM_W-1:0]             sum;
  logic [TIME_WIDTH-1:0]        acc_sat;

  logic [NUM_W-1:0]             div_num;
  logic [sfs_pkg::DEN_W-1:0]    div_den;
  logic [STEP_W-1:0]            div_steps;
  logic [NUM_W-1:0]             quo;
  logic [sfs_pkg::DEN_W-1:0]    rem;
  logic                         div_done;

  // Clamp register writes into their legal ranges
  always_comb begin
    if (cfg_wdata[sfs_pkg::COLS_W-1:0] == '0) begin
      cfg_cols = sfs_pkg::COLS_W'(1);
    end else if (int'(cfg_wdata[sfs_pkg::COLS_W-1:0]) > sfs_pkg::MAX_COLUMNS) begin
      cfg_cols = sfs_pkg::COLS_W'(sfs_pkg::MAX_COLUMNS);
    end else begin
      cfg_cols = cfg_wdata[sfs_pkg::COLS_W-1:0];
    end
    if (cfg_wdata[sfs_pkg::COUNT_W-1:0] == '0) begin
      cfg_count = sfs_pkg::COUNT_W'(1);
    end else if (int'(cfg_wdata[sfs_pkg::COUNT_W-1:0]) > sfs_pkg::MAX_FRAMES) begin
      cfg_count = sfs_pkg::COUNT_W'(sfs_pkg::MAX_FRAMES);
    end else begin
      cfg_count = cfg_wdata[sfs_pkg::COUNT_W-1:0];
    end
  end

  // Saturating accumulate
  always_comb begin
    sum     = SUM_W'(acc_r) + SUM_W'(delta_r);
    acc_sat = (|sum[SUM_W-1:TIME_WIDTH]) ? '1 : sum[TIME_WIDTH-1:0];
  end

  // Divider operand select
  always_comb begin
    case (cmd.div_sel)
      sfs_pkg::DSEL_SKIP: begin
        div_num   = (NUM_W'(acc_r) << 1) + NUM_W'(period_r);
        div_den   = {period_r, 1'b0};
        div_steps = STEP_W'(NUM_W);
      end
      sfs_pkg::DSEL_MOD: begin
        div_num   = num_r;
        div_den   = sfs_pkg::DEN_W'(count_r);
        div_steps = STEP_W'(NUM_W);
      end
      default: begin
        div_num   = {frame_r, {(NUM_W - sfs_pkg::FRAME_W){1'b0}}};
        div_den   = sfs_pkg::DEN_W'(cols_r);
        div_steps = STEP_W'(sfs_pkg::FRAME_W);
      end
    endcase
  end

  sfs_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (sfs_pkg::DEN_W),
    .STEP_W (STEP_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .quo   (quo),
    .rem   (rem),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= sfs_pkg::PERIOD_W'(sfs_pkg::PERIOD_RESET);
      cols_r    <= sfs_pkg::COLS_W'(1);
      count_r   <= sfs_pkg::COUNT_W'(1);
      acc_r     <= '0;
      frame_r   <= '0;
      running_r <= 1'b0;
      looping_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          sfs_pkg::REG_PERIOD: period_r <= (cfg_wdata == '0) ? sfs_pkg::PERIOD_W'(1) : cfg_wdata;
          sfs_pkg::REG_ACROSS: cols_r   <= cfg_cols;
          sfs_pkg::REG_DOWN:   ;  // row count does not shape any result
          sfs_pkg::REG_COUNT:  count_r  <= cfg_count;
        endcase
      end
      if (cmd.do_play) begin
        looping_r <= repeat_r;
        running_r <= 1'b1;
        frame_r   <= '0;
      end
      if (cmd.do_accum) begin
        acc_r <= acc_sat;
      end
      if (cmd.skip_add) begin
        acc_r <= '0;
      end
      if (cmd.take_num) begin
        frame_r <= num_r[sfs_pkg::FRAME_W-1:0];
      end
      if (cmd.take_rem) begin
        frame_r <= rem[sfs_pkg::FRAME_W-1:0];
      end
      if (cmd.stop) begin
        frame_r   <= '0;
        running_r <= 1'b0;
      end
    end
  end

  // Per-item payload, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= in_tuser;
      delta_r  <= in_tdata[sfs_pkg::PERIOD_W-1:0];
      repeat_r <= in_tdata[sfs_pkg::PERIOD_W];
      adv_r    <= 1'b0;
      fin_r    <= 1'b0;
    end
    if (cmd.skip_add) begin
      num_r <= NUM_W'(frame_r) + quo;
      adv_r <= 1'b1;
    end
    if (cmd.stop) begin
      fin_r <= 1'b1;
    end
    if (cmd.load_out) begin
      out_data_r <= {{PAD_W{1'b0}}, fin_r, adv_r, running_r, frame_r,
                     quo[sfs_pkg::FIELD_W-1:0], rem[sfs_pkg::FIELD_W-1:0]};
    end
  end

  always_comb begin
    status.action   = action_r;
    status.running  = running_r;
    status.looping  = looping_r;
    status.acc_ge   = (SUM_W'(acc_r) >= SUM_W'(period_r));
    status.num_ge   = (num_r >= NUM_W'(count_r));
    status.div_done = div_done;
  end

  assign out_tdata = out_data_r;

endmodule

[hdl/sfs_ctrl.sv]
// Controller: sequences each item through the datapath and owns the handshakes.
// Depends on sfs_pkg and the assertion macro header.
`include "sprite_frame_sequencer_unit_macros.svh"

module sfs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  sfs_pkg::dp_status_t status,
  output sfs_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV_SKIP,
    S_CHECK,
    S_DIV_MOD,
    S_CR_START,
    S_DIV_CR,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    cmd.div_sel   = sfs_pkg::DSEL_CR;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.action == sfs_pkg::ACT_PLAY) begin
          cmd.do_play = 1'b1;
          state_nxt   = S_CR_START;
        end else if (!status.running) begin
          state_nxt = S_CR_START;
        end else if (!status.acc_ge) begin
          cmd.do_accum = 1'b1;
          state_nxt    = S_CR_START;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = sfs_pkg::DSEL_SKIP;
          state_nxt     = S_DIV_SKIP;
        end
      end
      S_DIV_SKIP: begin
        if (status.div_done) begin
          cmd.skip_add = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.num_ge && status.looping) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = sfs_pkg::DSEL_MOD;
          state_nxt     = S_DIV_MOD;
        end else if (status.num_ge) begin
          cmd.stop  = 1'b1;
          state_nxt = S_CR_START;
        end else begin
          cmd.take_num = 1'b1;
          state_nxt    = S_CR_START;
        end
      end
      S_DIV_MOD: begin
        if (status.div_done) begin
          cmd.take_rem = 1'b1;
          state_nxt    = S_CR_START;
        end
      end
      S_CR_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_CR;
      end
      S_DIV_CR: begin
        if (status.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the result register is free
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  `SFS_ASSERT_SAME(a_done_in_wait, clk, rst_n, status.div_done,
    (state_r == S_DIV_SKIP) || (state_r == S_DIV_MOD) || (state_r == S_DIV_CR),
    "divider finished outside a wait state")
  `SFS_ASSERT_NEXT(a_start_not_done, clk, rst_n, cmd.div_start, !status.div_done,
    "divider reported done right after start")
  `SFS_ASSERT_SAME(a_load_free, clk, rst_n, cmd.load_out, !out_valid_r || out_tready,
    "result register overwritten while a transaction is pending")
  `SFS_ASSERT_SAME(a_stop_oneshot, clk, rst_n, cmd.stop, !status.looping && status.running,
    "stop issued on a looping or idle animation")

endmodule

[hdl/sprite_frame_sequencer_unit.sv]
// Sprite frame sequencer: steps a sprite-sheet animation from time ticks.
// Usage:
//   Input stream in_*: in_tuser is the kind (0 tick, 1 play); in_tdata carries
//   delta_us and repeat_mode. Every accepted item yields exactly one result on
//   out_*, carrying column, row, linear frame index and the playing, advanced
//   and finished flags. The user writes registers through cfg_* (index, data)
//   only while idle (not enforced); out-of-range values are clamped on write.
// Sequencing: one item at a time. A play, a stopped tick or an accumulating
//   tick runs through the 12-step column/row division before out_tvalid.
//   A tick that advances adds a skip division and a check step and, when a
//   loop wraps, a modulo division, each of NUM_W bits, NUM_W being
//   max(TIME_WIDTH,20)+2. All divisions share one restoring divider, one bit
//   per cycle. The next item can be taken in the cycle after a result is
//   loaded.
// Reset (rst_n low, synchronous): stopped, frame 0, accumulator 0, one-shot,
//   period 33333 us, one column, one frame, no result pending.
// Stall: a finished result waits in the output register; a new item is still
//   taken, and its result waits until the pending transaction completes.
module sprite_frame_sequencer_unit #(
  parameter int TIME_WIDTH = sfs_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [19:0] delta_us, [20] repeat_mode, [23:21] zero
  input  logic [sfs_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] action
  input  logic [0:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [5:0] frame_column, [11:6] frame_row, [23:12] frame_index,
  // [24] is_playing, [25] advanced, [26] finished, [31:27] zero
  output logic [sfs_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfs_pkg::PERIOD_W-1:0]     cfg_wdata
);

  sfs_pkg::ctrl_cmd_t  cmd;
  sfs_pkg::dp_status_t status;

  sfs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  sfs_dp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser[0]),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

endmodule
